// File: sv/integer_to_ascii_radix_unit_defines.svh
// Assertion macros for the checker file.
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITOA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itoa port check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itoa port check failed");

`endif

// File: sv/itoa_pkg.sv
package itoa_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned DIGIT_W    = 5;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ADDR_W     = $clog2(MAX_DIGITS);
  localparam int unsigned CHUNK_W    = 8;
  localparam int unsigned NUM_CHUNKS = VALUE_W / CHUNK_W;
  localparam int unsigned STEP_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd20;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;

  // Write port of the digit store
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [DIGIT_W-1:0] data;
  } ram_wr_t;

  // Digit value to ASCII; values of twenty and above have no character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 5'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < 5'd20) begin
      c = CHAR_LOWER + CHAR_W'(d - 5'd10);
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

// File: sv/itoa_div_step.sv
// One chunk of restoring long division by the radix
module itoa_div_step import itoa_pkg::*; (
  input  logic [RADIX_W-1:0] radix,
  input  logic [DIGIT_W-1:0] rem_in,
  input  logic [CHUNK_W-1:0] bits_in,
  output logic [CHUNK_W-1:0] quo_bits,
  output logic [DIGIT_W-1:0] rem_out
);

  always_comb begin
    logic [DIGIT_W:0] r;
    r        = {1'b0, rem_in};
    quo_bits = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], bits_in[i]};
      if (r >= {1'b0, radix}) begin
        r           = r - {1'b0, radix};
        quo_bits[i] = 1'b1;
      end
    end
    rem_out = r[DIGIT_W-1:0];
  end

endmodule

// File: sv/itoa_digit_ram.sv
// Digit store: one write port, one registered read port
module itoa_digit_ram import itoa_pkg::*; (
  input  logic               clk,
  input  ram_wr_t            wr,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/integer_to_ascii_radix_unit.sv
// Channel | Direction | Handshake                 | Payload
// in_     | request in| in_valid / in_stall       | in_value (signed)
// out_    | result out| out_valid / out_stall     | out_character, out_last
// cfg_    | write in  | cfg_valid / cfg_ready     | cfg_radix
//
// A request is accepted in ST_IDLE; each digit is then worked out in the
// shared divide unit, which works off 8 dividend bits a cycle, chunk by chunk;
// a negative value then gets a minus sign, and each digit goes through a
// digit store read (ST_RD) and an output register load (ST_EMIT).
// Reset (rst_n low, synchronous) sets radix to 10 and empties the pipeline.
// A stalled result holds in the output register; the next request is taken
// while the last character of the previous one still waits there.
module integer_to_ascii_radix_unit import itoa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_character,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [RADIX_W-1:0]        cfg_radix
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_EMIT
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_CHUNKS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  q_r, q_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                nz_r, nz_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    emit_r, emit_nxt;
  logic                neg_r, neg_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic [RADIX_W-1:0]  radix_eff_r, radix_eff_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [CHUNK_W-1:0]  quo_bits;
  logic [DIGIT_W-1:0]  rem_out;
  logic [DIGIT_W-1:0]  rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CNT_W-1:0]    rd_idx;
  ram_wr_t             ram_wr;
  logic                out_free;
  logic [VALUE_W-1:0]  in_bits;

  // Shared divide unit: top chunk of the running quotient each cycle
  itoa_div_step u_div (
    .radix    (radix_eff_r),
    .rem_in   (rem_r),
    .bits_in  (q_r[VALUE_W-1 -: CHUNK_W]),
    .quo_bits (quo_bits),
    .rem_out  (rem_out)
  );

  itoa_digit_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Digits come out most significant first: read entry emit_r - 1
  assign rd_idx   = emit_r - CNT_ONE;
  assign rd_addr  = rd_idx[ADDR_W-1:0];
  assign out_free = !out_valid_r || !out_stall;
  assign in_bits  = in_value;

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    nz_nxt        = nz_r;
    cnt_nxt       = cnt_r;
    emit_nxt      = emit_r;
    neg_nxt       = neg_r;
    radix_nxt     = radix_r;
    radix_eff_nxt = radix_eff_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_wr        = '0;

    // Config writes are always taken; the user must write only while idle, the block itself does not enforce it
    if (cfg_valid) begin
      radix_nxt = cfg_radix;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Take the magnitude; the most negative value wraps to 2^(W-1)
          neg_nxt = in_bits[VALUE_W-1];
          q_nxt   = in_bits[VALUE_W-1] ? (~in_bits + VALUE_W'(1)) : in_bits;
          if (radix_r < RADIX_MIN) begin
            radix_eff_nxt = RADIX_MIN;
          end else if (radix_r > RADIX_MAX) begin
            radix_eff_nxt = RADIX_MAX;
          end else begin
            radix_eff_nxt = radix_r;
          end
          rem_nxt   = '0;
          step_nxt  = '0;
          nz_nxt    = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Shift the new quotient bits in at the bottom
        q_nxt    = {q_r[VALUE_W-CHUNK_W-1:0], quo_bits};
        rem_nxt  = rem_out;
        nz_nxt   = nz_r | (|quo_bits);
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          // Digit done: store it unless the store is full, then drop it
          ram_wr.en   = (cnt_r < CNT_MAX);
          ram_wr.addr = cnt_r[ADDR_W-1:0];
          ram_wr.data = rem_out;
          if (cnt_r < CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_ONE;
          end
          rem_nxt  = '0;
          nz_nxt   = 1'b0;
          step_nxt = '0;
          if (!(nz_r | (|quo_bits))) begin
            emit_nxt  = (cnt_r < CNT_MAX) ? cnt_r + CNT_ONE : cnt_r;
            state_nxt = neg_r ? ST_SIGN : ST_RD;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        // Read address is presented this cycle, data lands next cycle
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_data);
          out_last_nxt  = (emit_r == CNT_ONE);
          emit_nxt      = emit_r - CNT_ONE;
          state_nxt     = (emit_r == CNT_ONE) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      radix_r     <= RADIX_RESET;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      q_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      radix_r     <= radix_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      q_r         <= q_nxt;
    end
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    nz_r        <= nz_nxt;
    emit_r      <= emit_nxt;
    radix_eff_r <= radix_eff_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

// File: sv/itoa_checker.sv
`include "integer_to_ascii_radix_unit_defines.svh"

module itoa_checker import itoa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last
);

  `ITOA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_character) && $stable(out_last))

  `ITOA_ASSERT_NOW(a_sign_not_last, out_valid && out_character == CHAR_MINUS, !out_last)

  `ITOA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  `ITOA_ASSERT_NOW(a_accept_after_digits, in_valid && !in_stall, !(out_valid && !out_last))

endmodule

bind integer_to_ascii_radix_unit itoa_checker u_itoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last      (out_last)
);
